[hw/rtl/waveform_min_max_decimator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the min/max peak decimator
// Shared concurrent-assertion forms; the third argument is the disable term.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MIN_MAX_DECIMATOR_UNIT_ASSERT_SVH
`define WAVEFORM_MIN_MAX_DECIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define MMD_ASSERT_IMP(lbl, clk_i, dis, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication
`define MMD_ASSERT_NXT(lbl, clk_i, dis, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

[hw/rtl/mmd_pkg.sv]
// ----------------------------------------------------------------------------
// mmd_pkg
// Shared widths, constants, types and helpers of the peak decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmd_pkg;

  localparam int INDEX_WIDTH_DEF  = 24;
  localparam int COLUMN_WIDTH_DEF = 12;

  localparam int SAMPLE_W   = 16;
  localparam int VIEW_W     = 24;
  localparam int ZOOM_W     = 32;
  localparam int TOTAL_W    = 25;
  localparam int HEIGHT_W   = 13;
  localparam int POS_W      = 25;   // wide enough for the sample count and any view start
  localparam int FRAC_W     = 16;   // Q16 fraction bits of the boundary
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 12;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int HALF_UP    = 32768;  // rounding bias of the boundary

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ROW_W-1:0]           row_t;
  typedef logic [HEIGHT_W-1:0]        height_t;

  // finished segment extremes handed from the tracker to the scaler
  typedef struct packed {
    logic    vld;
    sample_t hi;
    sample_t lo;
  } peak_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/waveform_min_max_decimator_unit.sv]
// ----------------------------------------------------------------------------
// waveform_min_max_decimator_unit
// Min/max peak decimator: one vertical segment per finished pixel column.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            word
//   in_*      sink       in_valid / in_stall  frame_start, sample_value
//   out_*     source     out_valid/out_stall  column_x, top_row, bottom_row
//   cfg_*     APB slave  psel/penable/pready  view_start, zoom, total, height
//
// One sample word per clock while in_stall is low. The tracker loop (boundary
// add, position compare) closes combinationally; a finished column's sample
// goes via the input, segment, multiply and output registers to out_*.
// Reset is synchronous (rst_n low) and clears all valids and tracking state.
// in_stall rises only when every stage downstream holds a word and out_stall
// is high; bubbles are squeezed out otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_min_max_decimator_unit import mmd_pkg::*; #(
  parameter int INDEX_WIDTH  = INDEX_WIDTH_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_frame_start,
  input  wire sample_t               in_sample_value,
  // segment output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COL_OUT_W-1:0]       out_column_x,
  output row_t                       out_top_row,
  output row_t                       out_bottom_row,
  // configuration
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic      [APB_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int BIAS_W = INDEX_WIDTH + FRAC_W + 1;

  // static view setup, registered along with the written register
  logic [POS_W-1:0]        vs_pos;
  logic [BIAS_W-1:0]       bias_init;
  logic [ZOOM_W-1:0]       zoom;
  logic [TOTAL_W-1:0]      total;
  height_t                 h_scale;

  // tracker -> scaler
  peak_t                   peak;
  logic [COLUMN_WIDTH-1:0] peak_col;
  logic                    scale_ready;

  mmd_cfg #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .vs_pos      (vs_pos),
    .bias_init   (bias_init),
    .zoom        (zoom),
    .total       (total),
    .h_scale     (h_scale)
  );

  // running extremes and column boundary; emits finished segments
  mmd_core #(
    .INDEX_WIDTH  (INDEX_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_frame_start  (in_frame_start),
    .in_sample_value (in_sample_value),
    .vs_pos          (vs_pos),
    .bias_init       (bias_init),
    .zoom            (zoom),
    .total           (total),
    .down_ready      (scale_ready),
    .peak            (peak),
    .peak_col        (peak_col)
  );

  // sample-to-row scaling, two stages, ends in the output register
  mmd_scale #(
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .peak           (peak),
    .peak_col       (peak_col),
    .h_scale        (h_scale),
    .up_ready       (scale_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column_x   (out_column_x),
    .out_top_row    (out_top_row),
    .out_bottom_row (out_bottom_row)
  );

endmodule

`default_nettype wire

[hw/rtl/mmd_cfg.sv]
// ----------------------------------------------------------------------------
// mmd_cfg
// APB register file plus values derived from it for the tracker and scaler.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_cfg import mmd_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [APB_ADDR_W-1:0]                 cfg_paddr,
  input  wire logic [APB_DATA_W-1:0]                 cfg_pwdata,
  output logic      [APB_DATA_W-1:0]                 cfg_prdata,
  output logic                                       cfg_pready,
  output logic      [POS_W-1:0]                      vs_pos,
  output logic      [INDEX_WIDTH+FRAC_W:0]           bias_init,
  output logic      [ZOOM_W-1:0]                     zoom,
  output logic      [TOTAL_W-1:0]                    total,
  output height_t                                    h_scale
);

  localparam int ACC_W  = INDEX_WIDTH + FRAC_W;
  localparam int BIAS_W = ACC_W + 1;
  localparam int SUM_W  = max_int(ACC_W, ZOOM_W) + 1;
  localparam logic [BIAS_W-1:0] BIAS_MAX = {1'b0, {ACC_W{1'b1}}} + BIAS_W'(HALF_UP);

  localparam logic [1:0] REG_VIEW_START   = 2'd0;
  localparam logic [1:0] REG_ZOOM_Q16     = 2'd1;
  localparam logic [1:0] REG_SAMPLE_TOTAL = 2'd2;
  localparam logic [1:0] REG_PLOT_HEIGHT  = 2'd3;

  localparam logic [VIEW_W-1:0]   VIEW_RST   = '0;
  localparam logic [ZOOM_W-1:0]   ZOOM_RST   = 32'd131072;
  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = '0;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd256;

  logic [VIEW_W-1:0]   view_start_r, view_start_nxt;
  logic [ZOOM_W-1:0]   zoom_q16_r, zoom_q16_nxt;
  logic [TOTAL_W-1:0]  sample_total_r, sample_total_nxt;
  logic [HEIGHT_W-1:0] plot_height_r, plot_height_nxt;

  logic [POS_W-1:0]    vs_pos_r, vs_pos_nxt;
  logic [BIAS_W-1:0]   bias_init_r, bias_init_nxt;
  height_t             h_r, h_nxt;

  logic [1:0]                   reg_idx;
  logic                         wr_en;
  logic [INDEX_WIDTH+VIEW_W-1:0] vs_wide;
  logic [INDEX_WIDTH-1:0]       vs_idx;
  logic [ACC_W-1:0]             vs_q;
  logic [SUM_W-1:0]             init_sum;

  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // register writes; reset folded into the next value
  always_comb begin
    view_start_nxt   = view_start_r;
    zoom_q16_nxt     = zoom_q16_r;
    sample_total_nxt = sample_total_r;
    plot_height_nxt  = plot_height_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_VIEW_START:   view_start_nxt   = cfg_pwdata[VIEW_W-1:0];
        REG_ZOOM_Q16:     zoom_q16_nxt     = cfg_pwdata[ZOOM_W-1:0];
        REG_SAMPLE_TOTAL: sample_total_nxt = cfg_pwdata[TOTAL_W-1:0];
        REG_PLOT_HEIGHT:  plot_height_nxt  = cfg_pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
    if (!rst_n) begin
      view_start_nxt   = VIEW_RST;
      zoom_q16_nxt     = ZOOM_RST;
      sample_total_nxt = TOTAL_RST;
      plot_height_nxt  = HEIGHT_RST;
    end
  end

  // derived values track the register next values, so no extra latency
  always_comb begin
    vs_wide    = {{INDEX_WIDTH{1'b0}}, view_start_nxt};
    vs_idx     = vs_wide[INDEX_WIDTH-1:0];
    vs_pos_nxt = POS_W'(vs_idx);
    // start boundary, pre-biased by one half: vs*2^16 + 0.5 + zoom, saturated
    vs_q       = {vs_idx, 16'h8000};
    init_sum   = SUM_W'(vs_q) + SUM_W'(zoom_q16_nxt);
    bias_init_nxt = (init_sum > SUM_W'(BIAS_MAX)) ? BIAS_MAX : BIAS_W'(init_sum);
    h_nxt      = (plot_height_nxt == '0) ? '0 : plot_height_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    view_start_r   <= view_start_nxt;
    zoom_q16_r     <= zoom_q16_nxt;
    sample_total_r <= sample_total_nxt;
    plot_height_r  <= plot_height_nxt;
    vs_pos_r       <= vs_pos_nxt;
    bias_init_r    <= bias_init_nxt;
    h_r            <= h_nxt;
  end

  always_comb begin
    unique case (reg_idx)
      REG_VIEW_START:   cfg_prdata = APB_DATA_W'(view_start_r);
      REG_ZOOM_Q16:     cfg_prdata = APB_DATA_W'(zoom_q16_r);
      REG_SAMPLE_TOTAL: cfg_prdata = APB_DATA_W'(sample_total_r);
      REG_PLOT_HEIGHT:  cfg_prdata = APB_DATA_W'(plot_height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign vs_pos    = vs_pos_r;
  assign bias_init = bias_init_r;
  assign zoom      = zoom_q16_r;
  assign total     = sample_total_r;
  assign h_scale   = h_r;

endmodule

`default_nettype wire

[hw/rtl/mmd_core.sv]
// ----------------------------------------------------------------------------
// mmd_core
// Input register, running min/max, column boundary tracking, segment register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_core import mmd_pkg::*; #(
  parameter int INDEX_WIDTH  = INDEX_WIDTH_DEF,
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_frame_start,
  input  wire sample_t                       in_sample_value,
  input  wire logic [POS_W-1:0]              vs_pos,
  input  wire logic [INDEX_WIDTH+FRAC_W:0]   bias_init,
  input  wire logic [ZOOM_W-1:0]             zoom,
  input  wire logic [TOTAL_W-1:0]            total,
  input  wire logic                          down_ready,
  output peak_t                              peak,
  output logic      [COLUMN_WIDTH-1:0]       peak_col
);

  localparam int ACC_W  = INDEX_WIDTH + FRAC_W;
  localparam int BIAS_W = ACC_W + 1;
  localparam int BSUM_W = max_int(BIAS_W, ZOOM_W) + 1;
  localparam int NIDX_W = BIAS_W - FRAC_W;
  localparam int CMP_W  = max_int(POS_W, NIDX_W);
  localparam int PT_W   = max_int(POS_W, TOTAL_W);
  localparam logic [BIAS_W-1:0] BIAS_MAX = {1'b0, {ACC_W{1'b1}}} + BIAS_W'(HALF_UP);
  localparam logic [BIAS_W-1:0] BIAS_RST = BIAS_W'(HALF_UP);

  // input register
  logic    s0_v_r, s0_v_nxt;
  logic    s0_fs_r;
  sample_t s0_smp_r;

  // tracking state; bias_r holds boundary + 0.5 in Q16
  sample_t                 run_min_r, run_min_nxt;
  sample_t                 run_max_r, run_max_nxt;
  logic [COLUMN_WIDTH-1:0] col_cnt_r, col_cnt_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic [BIAS_W-1:0]       bias_r, bias_nxt;

  // segment register
  logic                    s1_v_r, s1_v_nxt;
  sample_t                 s1_hi_r, s1_lo_r;
  logic [COLUMN_WIDTH-1:0] s1_col_r;

  logic                    take, accept, work, live, hit;
  logic [POS_W-1:0]        pos_e;
  logic [BIAS_W-1:0]       bias_e, bias_step;
  logic [BSUM_W-1:0]       bsum;
  logic [NIDX_W-1:0]       nidx;
  logic [COLUMN_WIDTH-1:0] col_e;
  sample_t                 min_e, max_e, min_b, max_b;

  assign take     = down_ready || !s1_v_r;
  assign in_stall = s0_v_r && !take;
  assign accept   = in_valid && !in_stall;
  assign work     = s0_v_r && take;

  always_comb begin
    // frame start reloads everything before the sample is looked at
    pos_e  = s0_fs_r ? vs_pos    : pos_r;
    bias_e = s0_fs_r ? bias_init : bias_r;
    col_e  = s0_fs_r ? '0        : col_cnt_r;
    min_e  = s0_fs_r ? '0        : run_min_r;
    max_e  = s0_fs_r ? '0        : run_max_r;

    live = PT_W'(pos_e) < PT_W'(total);
    nidx = bias_e[BIAS_W-1:FRAC_W];
    hit  = live && (CMP_W'(pos_e) >= CMP_W'(nidx));

    bsum      = BSUM_W'(bias_e) + BSUM_W'(zoom);
    bias_step = (bsum > BSUM_W'(BIAS_MAX)) ? BIAS_MAX : BIAS_W'(bsum);

    min_b = hit ? '0 : min_e;
    max_b = hit ? '0 : max_e;

    run_min_nxt = run_min_r;
    run_max_nxt = run_max_r;
    col_cnt_nxt = col_cnt_r;
    pos_nxt     = pos_r;
    bias_nxt    = bias_r;
    if (work) begin
      run_min_nxt = min_e;
      run_max_nxt = max_e;
      col_cnt_nxt = col_e;
      pos_nxt     = pos_e;
      bias_nxt    = bias_e;
      if (live) begin
        run_min_nxt = (s0_smp_r < min_b) ? s0_smp_r : min_b;
        run_max_nxt = (s0_smp_r > max_b) ? s0_smp_r : max_b;
        pos_nxt     = pos_e + 1'b1;
        if (hit) begin
          col_cnt_nxt = col_e + 1'b1;
          bias_nxt    = bias_step;
        end
      end
    end

    s0_v_nxt = s0_v_r;
    if (accept) begin
      s0_v_nxt = 1'b1;
    end else if (take) begin
      s0_v_nxt = 1'b0;
    end

    s1_v_nxt = s1_v_r;
    if (take) begin
      s1_v_nxt = work && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r    <= 1'b0;
      s1_v_r    <= 1'b0;
      run_min_r <= '0;
      run_max_r <= '0;
      col_cnt_r <= '0;
      pos_r     <= '0;
      bias_r    <= BIAS_RST;
    end else begin
      s0_v_r    <= s0_v_nxt;
      s1_v_r    <= s1_v_nxt;
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
      col_cnt_r <= col_cnt_nxt;
      pos_r     <= pos_nxt;
      bias_r    <= bias_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_fs_r  <= in_frame_start;
      s0_smp_r <= in_sample_value;
    end
    if (work && hit) begin
      s1_hi_r  <= max_e;
      s1_lo_r  <= min_e;
      s1_col_r <= col_e;
    end
  end

  assign peak.vld = s1_v_r;
  assign peak.hi  = s1_hi_r;
  assign peak.lo  = s1_lo_r;
  assign peak_col = s1_col_r;

endmodule

`default_nettype wire

[hw/rtl/mmd_scale.sv]
// ----------------------------------------------------------------------------
// mmd_scale
// Maps segment extremes to pixel rows: multiply stage, divide/round stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mmd_scale import mmd_pkg::*; #(
  parameter int COLUMN_WIDTH = COLUMN_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire peak_t                   peak,
  input  wire logic [COLUMN_WIDTH-1:0] peak_col,
  input  wire height_t                 h_scale,
  output logic                         up_ready,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic      [COL_OUT_W-1:0]    out_column_x,
  output row_t                         out_top_row,
  output row_t                         out_bottom_row
);

  localparam int PROD_W = HEIGHT_W + SAMPLE_W;
  localparam int M_W    = PROD_W + 1;
  localparam int Q_W    = M_W - FRAC_W + 1;
  localparam logic [M_W-1:0] HALF_DOWN = M_W'(32767);
  localparam logic [M_W:0]   DIV_K     = (M_W+1)'(65535);
  localparam logic [Q_W-1:0] ROW_MAX_Q = Q_W'(4095);

  // row = floor((h*(65535-u) + 32767) / 65535), saturated to 12 bits
  function automatic row_t row_of(input logic [PROD_W-1:0] p);
    logic [M_W-1:0] m;
    logic [M_W:0]   t;
    logic [M_W:0]   rem;
    logic [Q_W-1:0] q;
    m   = M_W'(p) + HALF_DOWN;
    t   = (M_W+1)'(m) + (M_W+1)'(m >> FRAC_W);
    q   = Q_W'(t >> FRAC_W);               // low by at most one
    rem = (M_W+1)'(m) + (M_W+1)'(q) - ((M_W+1)'(q) << FRAC_W);
    if (rem >= DIV_K) begin
      q = q + 1'b1;
    end
    return (q > ROW_MAX_Q) ? row_t'(ROW_MAX_Q) : q[ROW_W-1:0];
  endfunction

  logic                    s2_v_r, s2_v_nxt;
  logic [PROD_W-1:0]       s2_phi_r, s2_plo_r;
  logic [COLUMN_WIDTH-1:0] s2_col_r;

  logic                    out_v_r, out_v_nxt;
  row_t                    top_r, bot_r;
  logic [COL_OUT_W-1:0]    col_out_r;

  logic                    r3;
  logic [SAMPLE_W-1:0]     w_hi, w_lo;
  logic [COLUMN_WIDTH+COL_OUT_W-1:0] col_ext;

  assign r3       = !out_v_r || !out_stall;
  assign up_ready = !s2_v_r || r3;

  // 65535 - (v + 32768) = 32767 - v
  assign w_hi = {peak.hi[SAMPLE_W-1], ~peak.hi[SAMPLE_W-2:0]};
  assign w_lo = {peak.lo[SAMPLE_W-1], ~peak.lo[SAMPLE_W-2:0]};

  assign col_ext = {{COL_OUT_W{1'b0}}, s2_col_r};

  always_comb begin
    s2_v_nxt = s2_v_r;
    if (up_ready) begin
      s2_v_nxt = peak.vld;
    end
    out_v_nxt = out_v_r;
    if (r3) begin
      out_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && peak.vld) begin
      s2_phi_r <= PROD_W'(h_scale) * PROD_W'(w_hi);
      s2_plo_r <= PROD_W'(h_scale) * PROD_W'(w_lo);
      s2_col_r <= peak_col;
    end
    if (r3 && s2_v_r) begin
      top_r     <= row_of(s2_phi_r);
      bot_r     <= row_of(s2_plo_r);
      col_out_r <= col_ext[COL_OUT_W-1:0];
    end
  end

  assign out_valid      = out_v_r;
  assign out_column_x   = col_out_r;
  assign out_top_row    = top_r;
  assign out_bottom_row = bot_r;

endmodule

`default_nettype wire

[hw/rtl/mmd_checker.sv]
// ----------------------------------------------------------------------------
// mmd_checker
// Port-level checks on the decimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_min_max_decimator_unit_assert.svh"

module mmd_checker import mmd_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [COL_OUT_W-1:0] out_column_x,
  input wire row_t                 out_top_row,
  input wire row_t                 out_bottom_row,
  input wire logic                 cfg_psel,
  input wire logic                 cfg_pready
);

  // backpressure only once the output is full and blocked
  `MMD_ASSERT_IMP(a_stall_needs_full, clk, !rst_n, in_stall, out_valid && out_stall)

  // a held result word keeps its payload
  `MMD_ASSERT_NXT(a_out_hold, clk, !rst_n, out_valid && out_stall, out_valid && $stable(out_column_x) && $stable(out_top_row) && $stable(out_bottom_row))

  // reset leaves the block empty and open for input
  `MMD_ASSERT_NXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid && !in_stall)

  // zero-wait register port
  `MMD_ASSERT_IMP(a_pready_high, clk, !rst_n, cfg_psel || in_valid, cfg_pready)

endmodule

bind waveform_min_max_decimator_unit mmd_checker u_mmd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_column_x   (out_column_x),
  .out_top_row    (out_top_row),
  .out_bottom_row (out_bottom_row),
  .cfg_psel       (cfg_psel),
  .cfg_pready     (cfg_pready)
);

`default_nettype wire

[tb/waveform_min_max_decimator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waveform_min_max_decimator_unit_tb
// Self-checking bench for the min/max peak decimator. Sample words are fed
// from a queue under several idle/stall mixes, a cycle-free predictor tracks
// the column state, and every segment word on out_* is checked in order.
// ----------------------------------------------------------------------------

module waveform_min_max_decimator_unit_tb;
  import mmd_pkg::*;

  // register byte addresses on the cfg_* port
  localparam logic [APB_ADDR_W-1:0] ADDR_VIEW_START = 4'd0;
  localparam logic [APB_ADDR_W-1:0] ADDR_ZOOM       = 4'd4;
  localparam logic [APB_ADDR_W-1:0] ADDR_TOTAL      = 4'd8;
  localparam logic [APB_ADDR_W-1:0] ADDR_HEIGHT     = 4'd12;

  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off

  typedef struct packed {
    logic    fs;
    sample_t val;
  } word_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    row_t                 top;
    row_t                 bot;
  } segment_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic                  in_frame_start  = 1'b0;
  sample_t               in_sample_value = '0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [COL_OUT_W-1:0]  out_column_x;
  row_t                  out_top_row;
  row_t                  out_bottom_row;
  logic                  cfg_psel        = 1'b0;
  logic                  cfg_penable     = 1'b0;
  logic                  cfg_pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr       = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata      = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  waveform_min_max_decimator_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_frame_start (in_frame_start),
    .in_sample_value(in_sample_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_column_x   (out_column_x),
    .out_top_row    (out_top_row),
    .out_bottom_row (out_bottom_row),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  word_t    sample_q[$];    // sample words waiting to be offered
  segment_t segment_q[$];   // predicted segments, oldest first
  int       queued_cnt   = 0;
  int       accepted_cnt = 0;
  int       err_cnt      = 0;

  int send_idle_pct  = 0;   // chance the sender leaves a cycle empty
  int recv_stall_pct = 0;   // chance the receiver stalls a cycle

  // long hold-off: the stimulus bumps hold_req, the hold process counts it out
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;

  // register mirrors, reset values of the block
  logic [VIEW_W-1:0]   view_start_r = '0;
  logic [ZOOM_W-1:0]   zoom_r       = 32'h0002_0000;
  logic [TOTAL_W-1:0]  total_r      = '0;
  logic [HEIGHT_W-1:0] height_r     = 13'd256;

  // column tracker state, all zero after reset
  sample_t              trk_min   = '0;
  sample_t              trk_max   = '0;
  logic [COL_OUT_W-1:0] col_cnt   = '0;
  logic [POS_W-1:0]     pos       = '0;
  logic [39:0]          bound_acc = '0;   // Q16 boundary, saturating

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [39:0] sat_acc(input logic [39:0] a, input logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? '1 : s[39:0];
  endfunction

  // pixel row for a sample: h - (v+32768)*h/65535, rounded half up, clamped
  function automatic row_t row_for(input sample_t v, input logic [HEIGHT_W-1:0] hgt);
    longint unsigned h, u, num, r;
    h   = (hgt == '0) ? 0 : hgt - 1;
    u   = longint'(v) + 32768;
    num = 2 * (h * 65535 - u * h) + 65535;
    r   = num / 131070;
    return (r > 4095) ? row_t'(4095) : row_t'(r);
  endfunction

  // one accepted sample word; may close the current column
  function automatic void predict_segment(input logic fs, input sample_t v);
    logic [40:0] rnd;
    segment_t    seg;
    if (fs) begin
      col_cnt   = '0;
      pos       = {1'b0, view_start_r};
      bound_acc = sat_acc({view_start_r, 16'h0000}, {8'h00, zoom_r});
      trk_min   = '0;
      trk_max   = '0;
    end
    // past the end of the data: dropped, nothing moves
    if (pos >= total_r) return;
    rnd = {1'b0, bound_acc} + 41'h8000;
    if (pos >= rnd[40:16]) begin
      seg.col = col_cnt;
      seg.top = row_for(trk_max, height_r);
      seg.bot = row_for(trk_min, height_r);
      segment_q.push_back(seg);
      trk_min   = '0;
      trk_max   = '0;
      col_cnt   = col_cnt + 1'b1;
      bound_acc = sat_acc(bound_acc, {8'h00, zoom_r});
    end
    if (v < trk_min) trk_min = v;
    if (v > trk_max) trk_max = v;
    pos = pos + 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cap, well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("waveform_min_max_decimator_unit_tb NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: offers words from sample_q, feeds the predictor on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_segment(in_frame_start, in_sample_value);
        accepted_cnt++;
      end
      // free to move on once nothing is offered or the offer was taken
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = sample_q.pop_front();
          in_valid        <= 1'b1;
          in_frame_start  <= w.fs;
          in_sample_value <= w.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off counter, own process
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: drives out_stall, checks each accepted segment word in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    segment_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (segment_q.size() == 0) begin
          $display("%0t: unexpected segment col %0d top %0d bottom %0d", $time,
                   out_column_x, out_top_row, out_bottom_row);
          err_cnt++;
        end else begin
          want = segment_q.pop_front();
          if (out_column_x !== want.col) begin
            $display("%0t: column_x expected %0d got %0d", $time, want.col, out_column_x);
            err_cnt++;
          end
          if (out_top_row !== want.top) begin
            $display("%0t: top_row expected %0d got %0d", $time, want.top, out_top_row);
            err_cnt++;
          end
          if (out_bottom_row !== want.bot) begin
            $display("%0t: bottom_row expected %0d got %0d", $time, want.bot,
                     out_bottom_row);
            err_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      ADDR_VIEW_START: view_start_r = data[VIEW_W-1:0];
      ADDR_ZOOM:       zoom_r       = data[ZOOM_W-1:0];
      ADDR_TOTAL:      total_r      = data[TOTAL_W-1:0];
      ADDR_HEIGHT:     height_r     = data[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] vs, input logic [31:0] zm,
                            input logic [31:0] tot, input logic [31:0] hgt);
    cfg_write(ADDR_VIEW_START, vs);
    cfg_write(ADDR_ZOOM, zm);
    cfg_write(ADDR_TOTAL, tot);
    cfg_write(ADDR_HEIGHT, hgt);
  endtask

  task automatic queue_word(input logic fs, input sample_t val);
    sample_q.push_back('{fs, val});
    queued_cnt++;
  endtask

  // all words taken and all segments seen, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (accepted_cnt != queued_cnt || segment_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // extremes, small values around zero, and plain random words
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2, 3:    return sample_t'($urandom_range(64) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stim
    int ph, sg, k, vs, tot, hgt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No frame start yet: the tracker runs from reset, so the first word
    // closes column 0 at once with both extremes at zero.
    set_config(0, 32'h0001_0001, 40, 4096);
    queue_word(1'b0, sample_t'(16'h8000));
    queue_word(1'b0, sample_t'(16'h7FFF));
    queue_word(1'b0, sample_t'(16'h0000));
    queue_word(1'b0, sample_t'(16'hFFFF));
    queue_word(1'b1, sample_t'(16'h7FFF));
    queue_word(1'b0, sample_t'(16'h8000));
    queue_word(1'b0, sample_t'(16'h5555));
    queue_word(1'b0, sample_t'(16'hAAAA));
    queue_word(1'b0, sample_t'(16'h0001));
    queue_word(1'b0, sample_t'(16'hFFFE));
    wait_idle();

    // empty waveform: every word falls past the data
    cfg_write(ADDR_TOTAL, 0);
    queue_word(1'b1, sample_t'(16'h0007));
    queue_word(1'b0, sample_t'(16'hFFF9));
    wait_idle();

    // last index of the view with the widest zoom: boundary saturates
    set_config(24'hFF_FFFF, 32'hFFFF_FFFF, 32'h0100_0000, 256);
    queue_word(1'b1, sample_t'(16'h0064));
    queue_word(1'b0, sample_t'(16'h0064));
    wait_idle();

    // zoom of exactly one, height zero (all rows 0), run off the end of data
    set_config(5, 32'h0001_0000, 12, 0);
    queue_word(1'b1, sample_t'(16'h012C));
    for (k = 0; k < 7; k++) queue_word(1'b0, pick_sample());
    wait_idle();

    // view start already beyond the sample count
    set_config(20, 32'h0002_0000, 10, 1);
    queue_word(1'b1, sample_t'(16'h0005));
    wait_idle();

    // Zoom zero pins the boundary, so every word closes a column. Tall plot
    // saturates the rows. The receiver holds off for a long stretch meanwhile
    // so the block backs up.
    set_config(0, 0, 32'h0100_0000, 8191);
    hold_req <= hold_req + 1;
    queue_word(1'b1, pick_sample());
    for (k = 0; k < 59; k++) queue_word(1'b0, pick_sample());
    wait_idle();

    // Random part: framed runs of random words, a few stray frame starts,
    // under each idle/stall mix; fresh registers for every run.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (sg = 0; sg < 3; sg++) begin
        vs  = $urandom_range(1000);
        tot = vs + (($urandom_range(3) == 0) ? $urandom_range(60, 10)
                                             : $urandom_range(3000, 100));
        if ($urandom_range(9) == 0) tot = $urandom_range(vs);
        case ($urandom_range(3))
          0:       hgt = 1;
          1:       hgt = 4096;
          default: hgt = $urandom_range(4096, 1);
        endcase
        set_config(vs, $urandom_range(32'h0008_0000, 32'h0001_0001), tot, hgt);
        queue_word(1'b1, pick_sample());
        for (k = 0; k < 54; k++) queue_word($urandom_range(99) < 3, pick_sample());
        wait_idle();
      end
    end

    if (err_cnt == 0) begin
      $display("waveform_min_max_decimator_unit_tb OK");
    end else begin
      $display("waveform_min_max_decimator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_cfg.sv
hw/rtl/mmd_core.sv
hw/rtl/mmd_scale.sv
hw/rtl/waveform_min_max_decimator_unit.sv
hw/rtl/mmd_checker.sv
tb/waveform_min_max_decimator_unit_tb.sv
